// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL files that carry checks; the top level is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

`endif

// ----- hdl/mcs_pkg.sv -----
`timescale 1ns / 1ps

package mcs_pkg;

   // Fixed sizes of the block.
   localparam int MAX_BEATS_PER_BAR = 16;
   localparam int POSITION_BITS     = 48;
   localparam int FRAC_BITS         = 8;
   localparam int POINT_BITS        = POSITION_BITS + FRAC_BITS;
   localparam int PERIOD_BITS       = 32;
   localparam int BAR_BITS          = 5;
   localparam int BEAT_IDX_BITS     = $clog2(MAX_BEATS_PER_BAR);
   localparam int ACCENT_BITS       = 16;
   localparam int MULT_BITS         = 3;
   localparam int SWING_BITS        = 8;
   localparam int REQ_TYPE_BITS     = 3;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 32;
   localparam int PRODUCT_BITS      = 2 * PERIOD_BITS;
   localparam int SHIFT_BITS        = 6;

   // Depth of the command queue between front and back; a power of two.
   localparam int CMDQ_DEPTH        = 2;
   localparam int CMDQ_PTR_BITS     = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_COUNT_BITS   = $clog2(CMDQ_DEPTH + 1);

   // Reset values of the configuration registers.
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(3686400);
   localparam logic [PERIOD_BITS-1:0] PERIOD_MIN   = PERIOD_BITS'(256);
   localparam logic [BAR_BITS-1:0]    BAR_RESET    = BAR_BITS'(4);
   localparam logic [ACCENT_BITS-1:0] ACCENT_RESET = ACCENT_BITS'(1);
   localparam logic [MULT_BITS-1:0]   MULT_RESET   = MULT_BITS'(1);
   localparam logic [MULT_BITS-1:0]   MULT_MAX     = MULT_BITS'(4);
   localparam logic [SWING_BITS-1:0]  SWING_EVEN   = SWING_BITS'(128);

   // floor(p / 3) equals (p * DIV3_RECIP) >> DIV3_SHIFT for every 32-bit p.
   localparam logic [PERIOD_BITS-1:0] DIV3_RECIP   = 32'hAAAA_AAAB;
   localparam logic [SHIFT_BITS-1:0]  DIV3_SHIFT   = SHIFT_BITS'(33);

   // Request type codes on the input channel.
   localparam logic [REQ_TYPE_BITS-1:0] REQ_TICK   = REQ_TYPE_BITS'(0);
   localparam logic [REQ_TYPE_BITS-1:0] REQ_TEMPO  = REQ_TYPE_BITS'(1);
   localparam logic [REQ_TYPE_BITS-1:0] REQ_METER  = REQ_TYPE_BITS'(2);
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SUBDIV = REQ_TYPE_BITS'(3);
   localparam logic [REQ_TYPE_BITS-1:0] REQ_CANCEL = REQ_TYPE_BITS'(4);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEAT_PERIOD   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEATS_PER_BAR = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCENT        = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUBDIV_MULT   = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWING         = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MUTED         = CSR_INDEX_BITS'(5);

   typedef enum logic [2:0] {
      OP_TICK,
      OP_TEMPO,
      OP_METER,
      OP_SUBDIV,
      OP_CANCEL
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_APPLY,
      ST_FIX
   } back_state_type;

   // A classified request as it travels through the command queue.
   typedef struct packed {
      op_type                  op;
      logic [PERIOD_BITS-1:0]  period;
      logic [BAR_BITS-1:0]     bar;
      logic [MULT_BITS-1:0]    mult;
      logic [SWING_BITS-1:0]   swing;
   } cmd_type;

   // Scale factor and right shift that turn a period into an interval.
   typedef struct packed {
      logic [PERIOD_BITS-1:0]  k;
      logic [SHIFT_BITS-1:0]   sh;
   } scale_type;

   // Status of the back end, watched by the top level.
   typedef struct packed {
      logic                     idle;
      logic [BEAT_IDX_BITS-1:0] beat_index;
      logic [BAR_BITS-1:0]      bar_length;
   } status_type;

   function automatic logic [PERIOD_BITS-1:0] clamp_period(input logic [PERIOD_BITS-1:0] v);
      return (v < PERIOD_MIN) ? PERIOD_MIN : v;
   endfunction

   // Nearest whole sample of a Q.8 point, halves rounding up.
   function automatic logic [POSITION_BITS:0] round_point(input logic [POINT_BITS-1:0] p);
      return {1'b0, p[POINT_BITS-1:FRAC_BITS]} + (POSITION_BITS + 1)'(p[FRAC_BITS-1]);
   endfunction

   // Swing split with multiplier 2 and a ratio above even, otherwise period / multiplier.
   function automatic scale_type interval_scale(input logic [MULT_BITS-1:0]  mult,
                                                input logic [SWING_BITS-1:0] swing,
                                                input logic                  phase);
      scale_type s;
      s.k  = PERIOD_BITS'(1);
      s.sh = '0;
      if (mult == MULT_BITS'(2) && swing > SWING_EVEN) begin
         s.k  = phase ? PERIOD_BITS'((SWING_BITS + 1)'(256) - {1'b0, swing})
                      : PERIOD_BITS'(swing);
         s.sh = SHIFT_BITS'(FRAC_BITS);
      end else begin
         unique case (mult)
            MULT_BITS'(2): s.sh = SHIFT_BITS'(1);
            MULT_BITS'(3): begin
               s.k  = DIV3_RECIP;
               s.sh = DIV3_SHIFT;
            end
            MULT_BITS'(4): s.sh = SHIFT_BITS'(2);
            default:       s.sh = '0;
         endcase
      end
      return s;
   endfunction

endpackage

// ----- hdl/metronome_click_scheduler.sv -----
// Metronome click scheduler. Every accepted request of type tick stands for one audio
// sample; the block counts samples and, when the count meets the next beat point or the
// next subdivision point (both in samples with eight fraction bits, rounded to the
// nearest sample), produces one click result: a beat with its bar index and accent, or
// a subdivision click. Scheduled tempo, meter and subdivision changes are held and take
// effect at the next downbeat; a cancel request drops all held changes. Requests enter a
// two-entry command queue through push/full, so up to two requests can wait while the
// back end works. Requests that would change nothing, such as unknown types, are dropped
// by the front end and never reach the back end. The back end handles one request at a
// time: a scheduling request, or a tick that sets up no new subdivision point, needs only
// the evaluate state; a tick that sets one up also passes the multiply and apply states,
// as the interval comes from the shared 32 by 32 multiplier (period times a swing share,
// a reciprocal or one) and is then added in. A subdivision multiplier write above one
// holds the back end in the multiply, apply and fix states, with ready low. Results wait
// in a one-entry output register until popped; a click stalls the back end only while
// that register is still full. Muting hides the results but the timing state still advances.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module metronome_click_scheduler import mcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      push,
   output logic                      full,
   input  logic [REQ_TYPE_BITS-1:0]  req_type,
   input  logic [PERIOD_BITS-1:0]    req_new_beat_period,
   input  logic [BAR_BITS-1:0]       req_new_beats_per_bar,
   input  logic [MULT_BITS-1:0]      req_new_multiplier,
   input  logic [SWING_BITS-1:0]     req_new_swing,
   // Click result channel.
   output logic                      empty,
   input  logic                      pop,
   output logic                      rsp_is_beat,
   output logic                      rsp_accent,
   output logic [POSITION_BITS-1:0]  rsp_sample_index,
   output logic [BEAT_IDX_BITS-1:0]  rsp_bar_beat,
   // Configuration write channel.
   input  logic                      valid,
   output logic                      ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cmd_type    front_cmd;
   logic       front_push;
   cmd_type    cq_data;
   logic       cq_empty;
   logic       cq_pop;
   status_type back_status;

   // The front end decodes the request type, validates the scheduled values and drops
   // requests that would change nothing, such as unknown types.
   mcs_front u_front (
      .push                  (push),
      .full                  (full),
      .req_type              (req_type),
      .req_new_beat_period   (req_new_beat_period),
      .req_new_beats_per_bar (req_new_beats_per_bar),
      .req_new_multiplier    (req_new_multiplier),
      .req_new_swing         (req_new_swing),
      .cmd_push              (front_push),
      .cmd                   (front_cmd)
   );

   // The command queue decouples request acceptance from the back end.
   mcs_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_cmd),
      .full    (full),
      .rd_en   (cq_pop),
      .rd_data (cq_data),
      .empty   (cq_empty)
   );

   // The back end owns all timing state, the configuration registers and the result.
   mcs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cq_data          (cq_data),
      .cq_empty         (cq_empty),
      .cq_pop           (cq_pop),
      .csr_valid        (valid),
      .csr_ready        (ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_is_beat      (rsp_is_beat),
      .rsp_accent       (rsp_accent),
      .rsp_sample_index (rsp_sample_index),
      .rsp_bar_beat     (rsp_bar_beat),
      .status           (back_status)
   );

   // Configuration is taken only with the back end idle and no request queued.
   `ASSERT_IMPLIES(a_ready_idle, clock, reset, ready, back_status.idle && !full)
   // A subdivision click carries neither accent nor a bar index.
   `ASSERT_IMPLIES(a_sub_fields, clock, reset, !empty && !rsp_is_beat, !rsp_accent && rsp_bar_beat == '0)
   // The beat index always lies inside the active bar.
   `ASSERT_ALWAYS(a_beat_in_bar, clock, reset, BAR_BITS'(back_status.beat_index) < back_status.bar_length)

endmodule

// ----- hdl/mcs_front.sv -----
`timescale 1ns / 1ps

module mcs_front import mcs_pkg::*; (
   input  logic                     push,
   input  logic                     full,
   input  logic [REQ_TYPE_BITS-1:0] req_type,
   input  logic [PERIOD_BITS-1:0]   req_new_beat_period,
   input  logic [BAR_BITS-1:0]      req_new_beats_per_bar,
   input  logic [MULT_BITS-1:0]     req_new_multiplier,
   input  logic [SWING_BITS-1:0]    req_new_swing,
   output logic                     cmd_push,
   output cmd_type                  cmd
);

   logic keep;
   logic bar_ok;
   logic subdiv_ok;

   // Requests that change nothing are accepted and dropped here.
   assign bar_ok    = (req_new_beats_per_bar != '0) &&
                      (req_new_beats_per_bar <= BAR_BITS'(MAX_BEATS_PER_BAR));
   assign subdiv_ok = (req_new_multiplier != '0) && (req_new_multiplier <= MULT_MAX) &&
                      (req_new_swing >= SWING_EVEN);

   always_comb begin
      cmd.op     = OP_TICK;
      cmd.period = clamp_period(req_new_beat_period);
      cmd.bar    = req_new_beats_per_bar;
      cmd.mult   = req_new_multiplier;
      cmd.swing  = (req_new_multiplier == MULT_BITS'(2)) ? req_new_swing : SWING_EVEN;
      keep       = 1'b0;
      unique case (req_type)
         REQ_TICK: begin
            cmd.op = OP_TICK;
            keep   = 1'b1;
         end
         REQ_TEMPO: begin
            cmd.op = OP_TEMPO;
            keep   = 1'b1;
         end
         REQ_METER: begin
            cmd.op = OP_METER;
            keep   = bar_ok;
         end
         REQ_SUBDIV: begin
            cmd.op = OP_SUBDIV;
            keep   = subdiv_ok;
         end
         REQ_CANCEL: begin
            cmd.op = OP_CANCEL;
            keep   = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign cmd_push = push && !full && keep;

endmodule

// ----- hdl/mcs_cmd_queue.sv -----
`timescale 1ns / 1ps

module mcs_cmd_queue import mcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    empty
);

   cmd_type                    slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_COUNT_BITS-1:0] count_ff, count_in;
   logic                       do_wr;
   logic                       do_rd;

   assign full    = (count_ff == CMDQ_COUNT_BITS'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + CMDQ_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + CMDQ_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CMDQ_COUNT_BITS'(do_wr) - CMDQ_COUNT_BITS'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/mcs_back.sv -----
`timescale 1ns / 1ps

module mcs_back import mcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cq_data,
   input  logic                      cq_empty,
   output logic                      cq_pop,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_is_beat,
   output logic                      rsp_accent,
   output logic [POSITION_BITS-1:0]  rsp_sample_index,
   output logic [BEAT_IDX_BITS-1:0]  rsp_bar_beat,
   output status_type                status
);

   back_state_type             state_ff, state_in;
   cmd_type                    cmd_ff, cmd_in;
   logic [POSITION_BITS-1:0]   counter_ff, counter_in;
   logic [POINT_BITS-1:0]      nbp_ff, nbp_in;
   logic [POINT_BITS-1:0]      nsp_ff, nsp_in;
   logic [BEAT_IDX_BITS-1:0]   bib_ff, bib_in;
   logic                       phase_ff, phase_in;
   logic [PERIOD_BITS-1:0]     period_ff, period_in;
   logic [BAR_BITS-1:0]        bar_len_ff, bar_len_in;
   logic [MULT_BITS-1:0]       mult_ff, mult_in;
   logic [SWING_BITS-1:0]      swing_ff, swing_in;
   logic [ACCENT_BITS-1:0]     accent_ff, accent_in;
   logic                       muted_ff, muted_in;
   logic                       pp_valid_ff, pp_valid_in;
   logic [PERIOD_BITS-1:0]     pp_value_ff, pp_value_in;
   logic                       pb_valid_ff, pb_valid_in;
   logic [BAR_BITS-1:0]        pb_value_ff, pb_value_in;
   logic                       ps_valid_ff, ps_valid_in;
   logic [MULT_BITS-1:0]       ps_mult_ff, ps_mult_in;
   logic [SWING_BITS-1:0]      ps_swing_ff, ps_swing_in;
   logic                       rearm_ff, rearm_in;
   logic [POSITION_BITS-1:0]   cur_ff, cur_in;
   logic [PRODUCT_BITS-1:0]    mul_ff, mul_in;
   logic [SHIFT_BITS-1:0]      sh_ff, sh_in;
   logic [POINT_BITS:0]        ahead_ff, ahead_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_is_beat_ff, rsp_is_beat_in;
   logic                       rsp_accent_ff, rsp_accent_in;
   logic [POSITION_BITS-1:0]   rsp_index_ff, rsp_index_in;
   logic [BEAT_IDX_BITS-1:0]   rsp_bar_beat_ff, rsp_bar_beat_in;

   logic                       is_tick;
   logic                       beat_hit;
   logic                       sub_hit;
   logic                       emit;
   logic                       stall;
   logic                       downbeat;
   logic [PERIOD_BITS-1:0]     period_n;
   logic [BAR_BITS-1:0]        bar_len_n;
   logic [MULT_BITS-1:0]       mult_n;
   logic [SWING_BITS-1:0]      swing_n;
   logic [BAR_BITS-1:0]        bib_step;
   logic                       csr_take;
   logic [BAR_BITS-1:0]        csr_bar;
   logic [MULT_BITS-1:0]       csr_mult;
   logic [SWING_BITS-1:0]      csr_swing;
   logic                       csr_mult_ok;
   logic                       csr_rearm_mul;
   scale_type                  scale;
   logic [PERIOD_BITS-1:0]     interval;
   logic [POINT_BITS:0]        here;
   logic [POINT_BITS:0]        fix_diff;

   // Decisions of the current step.
   always_comb begin
      is_tick   = (cmd_ff.op == OP_TICK);
      beat_hit  = ({1'b0, counter_ff} == round_point(nbp_ff));
      sub_hit   = (mult_ff > MULT_BITS'(1)) && ({1'b0, counter_ff} == round_point(nsp_ff)) &&
                  !beat_hit;
      emit      = is_tick && (beat_hit || sub_hit) && !muted_ff;
      stall     = emit && rsp_valid_ff && !rsp_pop;
      downbeat  = (bib_ff == '0);
      period_n  = (downbeat && pp_valid_ff) ? pp_value_ff : period_ff;
      bar_len_n = (downbeat && pb_valid_ff) ? pb_value_ff : bar_len_ff;
      mult_n    = (downbeat && ps_valid_ff) ? ps_mult_ff  : mult_ff;
      swing_n   = (downbeat && ps_valid_ff) ? ps_swing_ff : swing_ff;
      bib_step  = {1'b0, bib_ff} + BAR_BITS'(1);
      csr_bar   = csr_data[BAR_BITS-1:0];
      csr_mult  = csr_data[MULT_BITS-1:0];
      csr_swing = csr_data[SWING_BITS-1:0];
      csr_mult_ok   = (csr_mult != '0) && (csr_mult <= MULT_MAX);
      csr_take      = csr_valid && csr_ready;
      csr_rearm_mul = csr_take && (csr_index == CSR_SUBDIV_MULT) && csr_mult_ok &&
                      (csr_mult > MULT_BITS'(1));
      scale     = interval_scale(mult_ff, swing_ff, phase_ff);
      interval  = PERIOD_BITS'(mul_ff >> sh_ff);
      here      = {1'b0, counter_ff, FRAC_BITS'(0)};
      fix_diff  = ahead_ff - (POINT_BITS + 1)'(period_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cq_empty) begin
               state_in = ST_EVAL;
            end else if (csr_rearm_mul) begin
               state_in = ST_MUL;
            end
         end
         ST_EVAL: begin
            if (!is_tick) begin
               state_in = ST_IDLE;
            end else if (stall) begin
               state_in = ST_EVAL;
            end else if (beat_hit ? (mult_n > MULT_BITS'(1)) : sub_hit) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL:   state_in = ST_APPLY;
         ST_APPLY: state_in = rearm_ff ? ST_FIX : ST_IDLE;
         ST_FIX:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs of the sequencer.
   always_comb begin
      cq_pop    = (state_ff == ST_IDLE) && !cq_empty;
      csr_ready = (state_ff == ST_IDLE) && cq_empty;
   end

   // Datapath next values.
   always_comb begin
      cmd_in          = cmd_ff;
      counter_in      = counter_ff;
      nbp_in          = nbp_ff;
      nsp_in          = nsp_ff;
      bib_in          = bib_ff;
      phase_in        = phase_ff;
      period_in       = period_ff;
      bar_len_in      = bar_len_ff;
      mult_in         = mult_ff;
      swing_in        = swing_ff;
      accent_in       = accent_ff;
      muted_in        = muted_ff;
      pp_valid_in     = pp_valid_ff;
      pp_value_in     = pp_value_ff;
      pb_valid_in     = pb_valid_ff;
      pb_value_in     = pb_value_ff;
      ps_valid_in     = ps_valid_ff;
      ps_mult_in      = ps_mult_ff;
      ps_swing_in     = ps_swing_ff;
      rearm_in        = rearm_ff;
      cur_in          = cur_ff;
      mul_in          = mul_ff;
      sh_in           = sh_ff;
      ahead_in        = ahead_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_pop;
      rsp_is_beat_in  = rsp_is_beat_ff;
      rsp_accent_in   = rsp_accent_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_bar_beat_in = rsp_bar_beat_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cq_pop) begin
               cmd_in   = cq_data;
               rearm_in = 1'b0;
            end
            if (csr_take) begin
               unique case (csr_index)
                  CSR_BEAT_PERIOD: period_in = clamp_period(csr_data);
                  CSR_BEATS_PER_BAR: begin
                     if (csr_bar != '0 && csr_bar <= BAR_BITS'(MAX_BEATS_PER_BAR)) begin
                        bar_len_in = csr_bar;
                        bib_in     = '0;
                     end
                  end
                  CSR_ACCENT: accent_in = csr_data[ACCENT_BITS-1:0];
                  CSR_SUBDIV_MULT: begin
                     if (csr_mult_ok) begin
                        mult_in  = csr_mult;
                        phase_in = 1'b0;
                        rearm_in = 1'b1;
                        if (csr_mult <= MULT_BITS'(1)) begin
                           nsp_in = '1;
                        end
                     end
                  end
                  CSR_SWING: begin
                     if (csr_swing >= SWING_EVEN) begin
                        swing_in = csr_swing;
                     end
                  end
                  CSR_MUTED: muted_in = csr_data[0];
                  default: ;
               endcase
            end
         end
         ST_EVAL: begin
            unique case (cmd_ff.op)
               OP_TICK: begin
                  if (!stall) begin
                     cur_in     = counter_ff;
                     counter_in = counter_ff + POSITION_BITS'(1);
                     if (emit) begin
                        rsp_valid_in    = 1'b1;
                        rsp_is_beat_in  = beat_hit;
                        rsp_accent_in   = beat_hit && accent_ff[bib_ff];
                        rsp_index_in    = counter_ff;
                        rsp_bar_beat_in = beat_hit ? bib_ff : '0;
                     end
                     if (beat_hit) begin
                        if (downbeat) begin
                           period_in   = period_n;
                           bar_len_in  = bar_len_n;
                           mult_in     = mult_n;
                           swing_in    = swing_n;
                           pp_valid_in = 1'b0;
                           pb_valid_in = 1'b0;
                           ps_valid_in = 1'b0;
                        end
                        bib_in = (bib_step >= bar_len_n) ? '0 : bib_step[BEAT_IDX_BITS-1:0];
                        nbp_in = nbp_ff + POINT_BITS'(period_n);
                        if (mult_n > MULT_BITS'(1)) begin
                           phase_in = 1'b0;
                        end
                     end else if (sub_hit) begin
                        phase_in = !phase_ff;
                     end
                  end
               end
               OP_TEMPO: begin
                  pp_valid_in = 1'b1;
                  pp_value_in = cmd_ff.period;
               end
               OP_METER: begin
                  pb_valid_in = 1'b1;
                  pb_value_in = cmd_ff.bar;
               end
               OP_SUBDIV: begin
                  ps_valid_in = 1'b1;
                  ps_mult_in  = cmd_ff.mult;
                  ps_swing_in = cmd_ff.swing;
               end
               OP_CANCEL: begin
                  pp_valid_in = 1'b0;
                  pb_valid_in = 1'b0;
                  ps_valid_in = 1'b0;
               end
               default: ;
            endcase
         end
         ST_MUL: begin
            mul_in = {{PERIOD_BITS{1'b0}}, period_ff} * {{PERIOD_BITS{1'b0}}, scale.k};
            sh_in  = scale.sh;
         end
         ST_APPLY: begin
            if (rearm_ff) begin
               ahead_in = {1'b0, nbp_ff} + (POINT_BITS + 1)'(interval);
            end else begin
               nsp_in = {cur_ff, FRAC_BITS'(0)} + POINT_BITS'(interval);
            end
         end
         ST_FIX: begin
            // Pull the point back one period when that still lies ahead of now.
            if (ahead_ff >= (POINT_BITS + 1)'(period_ff) && fix_diff > here) begin
               nsp_in = fix_diff[POINT_BITS-1:0];
            end else begin
               nsp_in = ahead_ff[POINT_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         nbp_ff       <= '0;
         nsp_ff       <= '1;
         bib_ff       <= '0;
         phase_ff     <= 1'b0;
         period_ff    <= PERIOD_RESET;
         bar_len_ff   <= BAR_RESET;
         mult_ff      <= MULT_RESET;
         swing_ff     <= SWING_EVEN;
         accent_ff    <= ACCENT_RESET;
         muted_ff     <= 1'b0;
         pp_valid_ff  <= 1'b0;
         pb_valid_ff  <= 1'b0;
         ps_valid_ff  <= 1'b0;
         rearm_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         nbp_ff       <= nbp_in;
         nsp_ff       <= nsp_in;
         bib_ff       <= bib_in;
         phase_ff     <= phase_in;
         period_ff    <= period_in;
         bar_len_ff   <= bar_len_in;
         mult_ff      <= mult_in;
         swing_ff     <= swing_in;
         accent_ff    <= accent_in;
         muted_ff     <= muted_in;
         pp_valid_ff  <= pp_valid_in;
         pb_valid_ff  <= pb_valid_in;
         ps_valid_ff  <= ps_valid_in;
         rearm_ff     <= rearm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      pp_value_ff     <= pp_value_in;
      pb_value_ff     <= pb_value_in;
      ps_mult_ff      <= ps_mult_in;
      ps_swing_ff     <= ps_swing_in;
      cur_ff          <= cur_in;
      mul_ff          <= mul_in;
      sh_ff           <= sh_in;
      ahead_ff        <= ahead_in;
      rsp_is_beat_ff  <= rsp_is_beat_in;
      rsp_accent_ff   <= rsp_accent_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_bar_beat_ff <= rsp_bar_beat_in;
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_is_beat      = rsp_is_beat_ff;
   assign rsp_accent       = rsp_accent_ff;
   assign rsp_sample_index = rsp_index_ff;
   assign rsp_bar_beat     = rsp_bar_beat_ff;

   assign status.idle       = (state_ff == ST_IDLE);
   assign status.beat_index = bib_ff;
   assign status.bar_length = bar_len_ff;

endmodule
